/* rtl/pli_pkg.sv */
// ----------------------------------------------------------------------------
// Piecewise linear interpolator package
// Operation codes, number format and the sequencer state codes of the
// interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam int DATA_W = 32;
    localparam int COUNT_W = 9;
    // fraction bits of x and y; the interpolation ratio is unitless, so no
    // datapath bit depends on it
    localparam int FRAC_BITS = 16;

    typedef logic [4:0] state_t;

    localparam state_t ST_IDLE    = 5'd0;
    localparam state_t ST_SRCH_RD = 5'd1;
    localparam state_t ST_SRCH_WT = 5'd2;
    localparam state_t ST_SRCH_CMP = 5'd3;
    localparam state_t ST_ADD_DEC = 5'd4;
    localparam state_t ST_SHF_RD  = 5'd5;
    localparam state_t ST_SHF_WT  = 5'd6;
    localparam state_t ST_SHF_WR  = 5'd7;
    localparam state_t ST_INS     = 5'd8;
    localparam state_t ST_Q_RD1   = 5'd9;
    localparam state_t ST_Q_WT1   = 5'd10;
    localparam state_t ST_Q_RD0   = 5'd11;
    localparam state_t ST_Q_WT0   = 5'd12;
    localparam state_t ST_Q_DEC   = 5'd13;
    localparam state_t ST_MUL     = 5'd14;
    localparam state_t ST_DIV     = 5'd15;
    localparam state_t ST_FIN     = 5'd16;
    localparam state_t ST_END_RD  = 5'd17;
    localparam state_t ST_END_WT  = 5'd18;
    localparam state_t ST_END_RD2 = 5'd19;
    localparam state_t ST_END_WT2 = 5'd20;
    localparam state_t ST_DONE    = 5'd21;
    localparam state_t ST_Q_FIRST = 5'd22;
    localparam state_t ST_Q_FWT   = 5'd23;

endpackage

/* rtl/pli_ram.sv */
// ----------------------------------------------------------------------------
// Piecewise linear interpolator RAM
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* rtl/pli_divider.sv */
// ----------------------------------------------------------------------------
// Piecewise linear interpolator divider
// Restoring divider, one quotient bit per cycle, 64 by 33 bits unsigned.
// ----------------------------------------------------------------------------
module pli_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [32:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic        rem_nz
);

    logic [63:0] quo_reg, quo_next;
    logic [33:0] rem_reg, rem_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [33:0] trial;
    logic [33:0] shifted;

    assign shifted = {rem_reg[32:0], quo_reg[63]};
    assign trial   = shifted - {1'b0, divisor};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // advance one quotient bit
            if (!trial[33])
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = busy_reg && (cnt_reg == 7'd1);
    assign quotient = quo_next;
    assign rem_nz   = (rem_next != '0);

endmodule

/* rtl/piecewise_linear_interpolator.sv */
// ----------------------------------------------------------------------------
// Piecewise linear interpolator
// Sorted breakpoint table with insert, clear and interpolating query.
// ----------------------------------------------------------------------------
// A beat is accepted when start is high and busy is low; the block then
// stays busy until it pulses done for one cycle with the result on its
// ports, and the receiver cannot stall it. Breakpoints live in two
// single-port RAMs (x and y) that a small sequencer drives over and over.
// Add and query begin with a binary search over the stored x values, each
// probe passing SRCH_RD, SRCH_WT and SRCH_CMP for the registered RAM read,
// at most log2(MAX_POINTS)+1 probes in all. An add then shifts the entries
// at and above the insertion point up one place, each moved through SHF_RD,
// SHF_WT and SHF_WR, then writes the new point. An interpolating query
// reads its two neighbours, runs one 32-by-32 multiply and one 64-by-33
// restoring divide, one bit per cycle. Every operation ends by reading the
// first and last x for min_x and max_x, then passes through the done state.
// A clear or an unused code goes straight to those reads; a dropped add
// skips the shift, and a query outside the range or on a breakpoint skips
// the multiply and divide.
// The RAM contents are undefined after reset; only entries below the point
// count ever reach a result, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    input  logic [1:0]          operation,
    input  logic signed [31:0]  x_in,
    input  logic signed [31:0]  y_in,
    output logic signed [31:0]  value_out,
    output logic signed [31:0]  min_x,
    output logic signed [31:0]  max_x,
    output logic [8:0]          point_count,
    output logic                dropped
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    pli_pkg::state_t state_reg, state_next;

    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  lo_reg, lo_next, hi_reg, hi_next, mid;
    logic [CW-1:0]  k_reg, k_next;
    logic [1:0]     op_reg, op_next;
    logic signed [31:0] xq_reg, xq_next, yq_reg, yq_next;
    logic signed [31:0] x1_reg, x1_next, y1_reg, y1_next;
    logic signed [31:0] val_reg, val_next;
    logic signed [31:0] minx_reg, minx_next, maxx_reg, maxx_next;
    logic           drop_reg, drop_next;
    logic [63:0]    prod_reg, prod_next;
    logic [32:0]    span_reg, span_next;
    logic           up_reg, up_next;

    // shared RAM port
    logic           ram_we;
    logic [AW-1:0]  ram_addr;
    logic [31:0]    ram_wx, ram_wy, ram_rx, ram_ry;

    // divider
    logic           div_start, div_done, div_rnz;
    logic [63:0]    div_quo;

    logic signed [32:0] dxs, dys;
    logic [32:0]    dmag;
    logic signed [33:0] wsum;

    pli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_xram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wx), .rdata(ram_rx)
    );
    pli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_yram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wy), .rdata(ram_ry)
    );

    pli_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(prod_reg), .divisor(span_reg),
        .done(div_done), .quotient(div_quo), .rem_nz(div_rnz)
    );

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign dxs = 33'(signed'(xq_reg)) - 33'(signed'(ram_rx));
    assign dys = 33'(signed'(y1_reg)) - 33'(signed'(ram_ry));
    assign dmag = dys[32] ? 33'(-dys) : 33'(dys);
    assign wsum = up_reg ? 34'(signed'(val_reg)) + 34'(signed'({1'b0, div_quo[32:0]}))
                         : 34'(signed'(val_reg)) - 34'(signed'({1'b0, div_quo[32:0]}));

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        k_next     = k_reg;
        op_next    = op_reg;
        xq_next    = xq_reg;
        yq_next    = yq_reg;
        x1_next    = x1_reg;
        y1_next    = y1_reg;
        val_next   = val_reg;
        minx_next  = minx_reg;
        maxx_next  = maxx_reg;
        drop_next  = drop_reg;
        prod_next  = prod_reg;
        span_next  = span_reg;
        up_next    = up_reg;
        ram_we     = 1'b0;
        ram_addr   = mid[AW-1:0];
        ram_wx     = xq_reg;
        ram_wy     = yq_reg;
        div_start  = 1'b0;

        unique case (state_reg)
            pli_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    op_next   = operation;
                    xq_next   = x_in;
                    yq_next   = y_in;
                    val_next  = '0;
                    drop_next = 1'b0;
                    lo_next   = '0;
                    hi_next   = count_reg;
                    if (operation == pli_pkg::OP_CLEAR)
                    begin
                        count_next = '0;
                        state_next = pli_pkg::ST_END_RD;
                    end
                    else if (operation == pli_pkg::OP_ADD
                             || operation == pli_pkg::OP_QUERY)
                    begin
                        state_next = pli_pkg::ST_SRCH_RD;
                    end
                    else
                    begin
                        state_next = pli_pkg::ST_END_RD;
                    end
                end
            end
            pli_pkg::ST_SRCH_RD:
            begin
                // probe mid, or leave the search when the range is empty
                if (lo_reg < hi_reg)
                begin
                    state_next = pli_pkg::ST_SRCH_WT;
                end
                else if (op_reg == pli_pkg::OP_ADD)
                begin
                    ram_addr   = lo_reg[AW-1:0];
                    state_next = pli_pkg::ST_ADD_DEC;
                end
                else
                begin
                    state_next = pli_pkg::ST_Q_RD1;
                end
            end
            pli_pkg::ST_SRCH_WT:
            begin
                state_next = pli_pkg::ST_SRCH_CMP;
            end
            pli_pkg::ST_SRCH_CMP:
            begin
                if (signed'(ram_rx) < xq_reg)
                begin
                    lo_next = mid + CW'(1);
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = pli_pkg::ST_SRCH_RD;
            end
            pli_pkg::ST_ADD_DEC:
            begin
                // ram_rx holds x at the insertion point (read at lo)
                if (lo_reg < count_reg && signed'(ram_rx) == xq_reg)
                begin
                    drop_next  = 1'b1;
                    state_next = pli_pkg::ST_END_RD;
                end
                else if (count_reg >= CW'(MAX_POINTS))
                begin
                    drop_next  = 1'b1;
                    state_next = pli_pkg::ST_END_RD;
                end
                else
                begin
                    k_next     = count_reg;
                    state_next = pli_pkg::ST_SHF_RD;
                end
            end
            pli_pkg::ST_SHF_RD:
            begin
                if (k_reg > lo_reg)
                begin
                    ram_addr   = AW'(k_reg - CW'(1));
                    state_next = pli_pkg::ST_SHF_WT;
                end
                else
                begin
                    state_next = pli_pkg::ST_INS;
                end
            end
            pli_pkg::ST_SHF_WT:
            begin
                ram_addr   = AW'(k_reg - CW'(1));
                state_next = pli_pkg::ST_SHF_WR;
            end
            pli_pkg::ST_SHF_WR:
            begin
                // move one entry up a place
                ram_we     = 1'b1;
                ram_addr   = k_reg[AW-1:0];
                ram_wx     = ram_rx;
                ram_wy     = ram_ry;
                k_next     = k_reg - CW'(1);
                state_next = pli_pkg::ST_SHF_RD;
            end
            pli_pkg::ST_INS:
            begin
                ram_we     = 1'b1;
                ram_addr   = lo_reg[AW-1:0];
                count_next = count_reg + CW'(1);
                state_next = pli_pkg::ST_END_RD;
            end
            pli_pkg::ST_Q_RD1:
            begin
                // lo is the first index with x >= query
                if (count_reg == '0)
                begin
                    state_next = pli_pkg::ST_END_RD;
                end
                else if (lo_reg == '0)
                begin
                    ram_addr   = '0;
                    state_next = pli_pkg::ST_Q_FIRST;
                end
                else if (lo_reg >= count_reg)
                begin
                    ram_addr   = AW'(count_reg - CW'(1));
                    state_next = pli_pkg::ST_Q_FIRST;
                end
                else
                begin
                    ram_addr   = lo_reg[AW-1:0];
                    state_next = pli_pkg::ST_Q_WT1;
                end
            end
            pli_pkg::ST_Q_FIRST:
            begin
                ram_addr   = (lo_reg == '0) ? '0 : AW'(count_reg - CW'(1));
                state_next = pli_pkg::ST_Q_FWT;
            end
            pli_pkg::ST_Q_FWT:
            begin
                val_next   = ram_ry;
                state_next = pli_pkg::ST_END_RD;
            end
            pli_pkg::ST_Q_WT1:
            begin
                ram_addr   = lo_reg[AW-1:0];
                state_next = pli_pkg::ST_Q_RD0;
            end
            pli_pkg::ST_Q_RD0:
            begin
                x1_next = ram_rx;
                y1_next = ram_ry;
                if (signed'(ram_rx) == xq_reg)
                begin
                    val_next   = ram_ry;
                    state_next = pli_pkg::ST_END_RD;
                end
                else
                begin
                    ram_addr   = AW'(lo_reg - CW'(1));
                    state_next = pli_pkg::ST_Q_WT0;
                end
            end
            pli_pkg::ST_Q_WT0:
            begin
                ram_addr   = AW'(lo_reg - CW'(1));
                state_next = pli_pkg::ST_Q_DEC;
            end
            pli_pkg::ST_Q_DEC:
            begin
                // ram holds x0, y0; dx and |dy| both fit in 32 bits
                val_next   = ram_ry;
                span_next  = 33'(33'(signed'(x1_reg)) - 33'(signed'(ram_rx)));
                prod_next  = {31'd0, dxs[32:0]};
                up_next    = !dys[32];
                y1_next    = 32'(dmag);
                state_next = pli_pkg::ST_MUL;
            end
            pli_pkg::ST_MUL:
            begin
                // 32 by 32 unsigned: dx times |dy|
                prod_next  = {32'd0, prod_reg[31:0]} * {32'd0, y1_reg};
                state_next = pli_pkg::ST_DIV;
            end
            pli_pkg::ST_DIV:
            begin
                div_start  = 1'b1;
                state_next = pli_pkg::ST_FIN;
            end
            pli_pkg::ST_FIN:
            begin
                if (div_done)
                begin
                    if (div_rnz && up_reg && wsum[33])
                    begin
                        val_next = 32'(wsum + 34'sd1);
                    end
                    else if (div_rnz && !up_reg && !wsum[33] && wsum != '0)
                    begin
                        val_next = 32'(wsum - 34'sd1);
                    end
                    else
                    begin
                        val_next = 32'(wsum);
                    end
                    state_next = pli_pkg::ST_END_RD;
                end
            end
            pli_pkg::ST_END_RD:
            begin
                ram_addr   = '0;
                state_next = pli_pkg::ST_END_WT;
            end
            pli_pkg::ST_END_WT:
            begin
                // hold the first address so its data is still there next cycle
                ram_addr   = '0;
                state_next = pli_pkg::ST_END_RD2;
            end
            pli_pkg::ST_END_RD2:
            begin
                minx_next  = (count_reg == '0) ? '0 : ram_rx;
                ram_addr   = AW'(count_reg - CW'(1));
                state_next = pli_pkg::ST_END_WT2;
            end
            pli_pkg::ST_END_WT2:
            begin
                maxx_next  = (count_reg == '0) ? '0 : ram_rx;
                state_next = pli_pkg::ST_DONE;
            end
            pli_pkg::ST_DONE:
            begin
                state_next = pli_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pli_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pli_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        k_reg    <= k_next;
        op_reg   <= op_next;
        xq_reg   <= xq_next;
        yq_reg   <= yq_next;
        x1_reg   <= x1_next;
        y1_reg   <= y1_next;
        val_reg  <= val_next;
        minx_reg <= minx_next;
        maxx_reg <= maxx_next;
        drop_reg <= drop_next;
        prod_reg <= prod_next;
        span_reg <= span_next;
        up_reg   <= up_next;
    end

    assign busy        = (state_reg != pli_pkg::ST_IDLE);
    assign done        = (state_reg == pli_pkg::ST_DONE);
    assign value_out   = val_reg;
    assign min_x       = minx_reg;
    assign max_x       = maxx_reg;
    assign point_count = 9'(count_reg);
    assign dropped     = drop_reg;

`ifndef SYNTH
    // the table never holds more points than it has room for
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond table size");

    // a drop never comes with a grown table
    a_drop_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (done && dropped) |-> $stable(count_reg))
        else $error("dropped add changed the count");

    // an accepted beat makes the block busy next cycle
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");
`endif

endmodule
